[hdl/twctl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twctl_pkg
// Shared sizes, types and state codes of the two-way cache tag directory.
// ----------------------------------------------------------------------------
package twctl_pkg;

  localparam int NUM_SETS  = 64;
  localparam int TAG_WIDTH = 8;
  localparam int SET_W     = $clog2(NUM_SETS);
  localparam int ADDR_W    = 16;
  localparam int SET_LSB   = 2;
  localparam int TAG_LSB   = 8;
  localparam int SET_OUT_W = 6;
  localparam int TAG_OUT_W = 8;
  localparam int CNT_W     = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SET_W-1:0]     set_t;
  typedef logic [TAG_WIDTH-1:0] tag_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    tag_t tag;
    set_t set;
  } lookup_t;

  typedef enum logic {
    BK_IDLE,
    BK_LOOK
  } back_state_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

[hdl/two_way_cache_tag_lru_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_way_cache_tag_lru_core
// Tag directory of a 2-way set-associative cache with one LRU bit per set.
//
// The in_ channel takes one 16-bit byte address per transaction. The out_
// channel returns one transaction per address: hit flag, way that hit or was
// filled, set index, tag, and the four saturating hit/miss counters as they
// stand after this lookup.
// A two-entry queue decouples acceptance from lookup. The back end does each
// lookup in two steps: one reads both tag RAMs, the other compares, updates
// valid, LRU and counters, and loads the result register. It finishes one
// address before it takes the next from the queue; an accepted address goes
// through the queue, the tag RAM read and the compare step to out_valid.
// With a result waiting and out_ready low the result register holds; the
// back end stops before its next lookup; the queue takes addresses till full.
// Synchronous reset clears all valid bits, LRU bits, counters and the queue;
// the block accepts addresses on the first cycle after reset.
// ----------------------------------------------------------------------------
module two_way_cache_tag_lru_core import twctl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ADDR_W-1:0]    in_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic                 out_way,
  output logic [SET_OUT_W-1:0] out_set_index,
  output logic [TAG_OUT_W-1:0] out_line_tag,
  output logic [CNT_W-1:0]     out_hits_way_zero,
  output logic [CNT_W-1:0]     out_hits_way_one,
  output logic [CNT_W-1:0]     out_misses_way_zero,
  output logic [CNT_W-1:0]     out_misses_way_one
);

  logic    q_valid;
  lookup_t q_head;
  logic    q_pop;

  twctl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_address (in_address),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  twctl_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit             (out_hit),
    .out_way             (out_way),
    .out_set_index       (out_set_index),
    .out_line_tag        (out_line_tag),
    .out_hits_way_zero   (out_hits_way_zero),
    .out_hits_way_one    (out_hits_way_one),
    .out_misses_way_zero (out_misses_way_zero),
    .out_misses_way_one  (out_misses_way_one)
  );

endmodule

[hdl/twctl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twctl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twctl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/twctl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twctl_front
// Accept addresses, split them into set and tag, and queue them for lookup.
// ----------------------------------------------------------------------------
module twctl_front import twctl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ADDR_W-1:0] in_address,
  output logic              q_valid,
  output lookup_t           q_head,
  input  logic              q_pop
);

  lookup_t             q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push;
  logic                pop;
  lookup_t             entry;

  assign in_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_head   = q_mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    entry.set  = in_address[SET_LSB +: SET_W];
    entry.tag  = TAG_WIDTH'(in_address >> TAG_LSB);
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= entry;
    end
  end

endmodule

[hdl/twctl_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twctl_back
// Look up one queued address: read both tag ways, resolve hit or fill,
// update valid, LRU and counters, and present the result.
// ----------------------------------------------------------------------------
module twctl_back import twctl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  lookup_t              q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic                 out_way,
  output logic [SET_OUT_W-1:0] out_set_index,
  output logic [TAG_OUT_W-1:0] out_line_tag,
  output logic [CNT_W-1:0]     out_hits_way_zero,
  output logic [CNT_W-1:0]     out_hits_way_one,
  output logic [CNT_W-1:0]     out_misses_way_zero,
  output logic [CNT_W-1:0]     out_misses_way_one
);

  back_state_t         state_r, state_nxt;
  lookup_t             cur_r;
  logic [NUM_SETS-1:0] valid0_r, valid0_nxt;
  logic [NUM_SETS-1:0] valid1_r, valid1_nxt;
  logic [NUM_SETS-1:0] lru_r, lru_nxt;
  cnt_t                hit0_r, hit0_nxt;
  cnt_t                hit1_r, hit1_nxt;
  cnt_t                miss0_r, miss0_nxt;
  cnt_t                miss1_r, miss1_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic                out_way_r, out_way_nxt;
  lookup_t             out_id_r, out_id_nxt;
  tag_t                rd_tag0, rd_tag1;
  logic                hit0, hit1, hit, way;
  logic                we0, we1;

  twctl_ram #(.WIDTH(TAG_WIDTH), .DEPTH(NUM_SETS)) u_tag0 (
    .clk     (clk),
    .wr_en   (we0),
    .wr_addr (cur_r.set),
    .wr_data (cur_r.tag),
    .rd_addr (q_head.set),
    .rd_data (rd_tag0)
  );

  twctl_ram #(.WIDTH(TAG_WIDTH), .DEPTH(NUM_SETS)) u_tag1 (
    .clk     (clk),
    .wr_en   (we1),
    .wr_addr (cur_r.set),
    .wr_data (cur_r.tag),
    .rd_addr (q_head.set),
    .rd_data (rd_tag1)
  );

  always_comb begin
    hit0 = valid0_r[cur_r.set] && (rd_tag0 == cur_r.tag);
    hit1 = valid1_r[cur_r.set] && (rd_tag1 == cur_r.tag);
    hit  = hit0 || hit1;
    priority if (hit0) begin
      way = 1'b0;
    end else if (hit1) begin
      way = 1'b1;
    end else if (!valid0_r[cur_r.set]) begin
      way = 1'b0;
    end else if (!valid1_r[cur_r.set]) begin
      way = 1'b1;
    end else begin
      way = lru_r[cur_r.set];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    we0           = 1'b0;
    we1           = 1'b0;
    valid0_nxt    = valid0_r;
    valid1_nxt    = valid1_r;
    lru_nxt       = lru_r;
    hit0_nxt      = hit0_r;
    hit1_nxt      = hit1_r;
    miss0_nxt     = miss0_r;
    miss1_nxt     = miss1_r;
    out_hit_nxt   = out_hit_r;
    out_way_nxt   = out_way_r;
    out_id_nxt    = out_id_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && (!out_valid_r || out_ready)) begin
          q_pop     = 1'b1;
          state_nxt = BK_LOOK;
        end
      end
      BK_LOOK: begin
        if (hit) begin
          if (way) begin
            hit1_nxt = sat_inc(hit1_r);
          end else begin
            hit0_nxt = sat_inc(hit0_r);
          end
        end else if (way) begin
          we1                   = 1'b1;
          valid1_nxt[cur_r.set] = 1'b1;
          miss1_nxt             = sat_inc(miss1_r);
        end else begin
          we0                   = 1'b1;
          valid0_nxt[cur_r.set] = 1'b1;
          miss0_nxt             = sat_inc(miss0_r);
        end
        lru_nxt[cur_r.set] = !way;
        out_hit_nxt        = hit;
        out_way_nxt        = way;
        out_id_nxt         = cur_r;
        out_valid_nxt      = 1'b1;
        state_nxt          = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      valid0_r    <= '0;
      valid1_r    <= '0;
      lru_r       <= '0;
      hit0_r      <= '0;
      hit1_r      <= '0;
      miss0_r     <= '0;
      miss1_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid0_r    <= valid0_nxt;
      valid1_r    <= valid1_nxt;
      lru_r       <= lru_nxt;
      hit0_r      <= hit0_nxt;
      hit1_r      <= hit1_nxt;
      miss0_r     <= miss0_nxt;
      miss1_r     <= miss1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    out_hit_r <= out_hit_nxt;
    out_way_r <= out_way_nxt;
    out_id_r  <= out_id_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_way             = out_way_r;
  assign out_set_index       = SET_OUT_W'(out_id_r.set);
  assign out_line_tag        = TAG_OUT_W'(out_id_r.tag);
  assign out_hits_way_zero   = hit0_r;
  assign out_hits_way_one    = hit1_r;
  assign out_misses_way_zero = miss0_r;
  assign out_misses_way_one  = miss1_r;

endmodule
